// ===== src/pct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers for the primitive collision tester.
// Used by every module of the tester pipeline; depends on nothing.
package pct_pkg;

    localparam int CW   = 16;                 // coordinate and size width
    localparam int DW   = CW + 1;             // signed coordinate difference
    localparam int SQW  = 2 * CW + 1;         // sum of two squares
    localparam int PW   = 2 * DW + 1;         // dot and cross products
    localparam int CMW  = 2 * DW;             // magnitude of the cross product
    localparam int HW   = CMW / 2;            // split point for the wide products
    localparam int CHW  = CMW - HW;
    localparam int LHW  = SQW - HW;
    localparam int R2W  = 2 * CW;             // radius squared
    localparam int TH2W = 2 * DW;             // threshold squared
    localparam int C2W  = 2 * CMW;            // cross squared
    localparam int RLW  = R2W + SQW;          // radius squared times length squared
    localparam int NFLD = 10;
    localparam int SDW  = ((NFLD * CW + 7) / 8) * 8;
    localparam int AW   = 3;
    localparam int MDW  = 8;

    localparam int FLD_AX = 0;
    localparam int FLD_AY = 1;
    localparam int FLD_AW = 2;
    localparam int FLD_AH = 3;
    localparam int FLD_BX = 4;
    localparam int FLD_BY = 5;
    localparam int FLD_BW = 6;
    localparam int FLD_BH = 7;
    localparam int FLD_EX = 8;
    localparam int FLD_EY = 9;

    typedef enum logic [AW-1:0] {
        ACT_CIRC_CIRC = 3'd0,
        ACT_CIRC_PT   = 3'd1,
        ACT_CIRC_BOX  = 3'd2,
        ACT_BOX_BOX   = 3'd3,
        ACT_BOX_PT    = 3'd4,
        ACT_CIRC_SEG  = 3'd5,
        ACT_PT_PT     = 3'd6
    } t_action;

    typedef struct packed {
        t_action               action;
        logic signed [DW-1:0]  dab_x;
        logic signed [DW-1:0]  dab_y;
        logic signed [DW-1:0]  dse_x;
        logic signed [DW-1:0]  dse_y;
        logic signed [DW-1:0]  dae_x;
        logic signed [DW-1:0]  dae_y;
        logic [CW-1:0]         aw;
        logic [CW-1:0]         ah;
        logic [CW-1:0]         bw;
        logic [CW-1:0]         bh;
        logic [DW-1:0]         rsum;
    } t_s1;

    typedef struct packed {
        t_action               action;
        logic                  hit_box;
        logic [CW-1:0]         m1x;
        logic [CW-1:0]         m1y;
        logic [CW-1:0]         mex;
        logic [CW-1:0]         mey;
        logic [CW-1:0]         mlx;
        logic [CW-1:0]         mly;
        logic signed [DW-1:0]  dab_x;
        logic signed [DW-1:0]  dab_y;
        logic signed [DW-1:0]  dse_x;
        logic signed [DW-1:0]  dse_y;
        logic [DW-1:0]         thr;
    } t_s2;

    typedef struct packed {
        t_action               action;
        logic                  hit_box;
        logic [SQW-1:0]        dist1;
        logic [SQW-1:0]        diste;
        logic [SQW-1:0]        len2;
        logic [TH2W-1:0]       thr2;
        logic signed [PW-1:0]  dot;
        logic signed [PW-1:0]  xprod;
    } t_s3;

    typedef struct packed {
        logic                  use_cross;
        logic                  hit_pre;
        logic [CMW-1:0]        cm;
        logic [R2W-1:0]        r2;
        logic [SQW-1:0]        len2;
    } t_s4;

    typedef struct packed {
        logic                  use_cross;
        logic                  hit_pre;
        logic [2*CHW-1:0]      pp_hh;
        logic [CHW+HW-1:0]     pp_hl;
        logic [2*HW-1:0]       pp_ll;
        logic [R2W+LHW-1:0]    rl_h;
        logic [R2W+HW-1:0]     rl_l;
    } t_s5;

    typedef struct packed {
        logic                  use_cross;
        logic                  hit_pre;
        logic [C2W-1:0]        c2;
        logic [RLW-1:0]        rl;
    } t_s6;

    function automatic logic [CW-1:0] mag(input logic signed [DW-1:0] v);
        mag = v[DW-1] ? CW'(-v) : CW'(v);
    endfunction

    function automatic logic [R2W-1:0] sq(input logic [CW-1:0] v);
        sq = R2W'(v) * R2W'(v);
    endfunction

    function automatic logic signed [2*DW-1:0] smul(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        smul = (2*DW)'(a) * (2*DW)'(b);
    endfunction

endpackage

// ===== src/pct_front.sv =====
`timescale 1ns / 1ps
// Front stages: unpack the beat, form coordinate differences, then magnitudes,
// box clamping and the box and point tests. Depends on pct_pkg.
module pct_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [pct_pkg::AW-1:0]  i_action,
    input  logic [pct_pkg::SDW-1:0] i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output pct_pkg::t_s2          o_s2,
    input  logic                  i_ready
);
    import pct_pkg::*;

    logic signed [CW-1:0] ax, ay, bx, by, ex, ey;
    logic [CW-1:0]        aw, ah, bw, bh;
    logic                 adv1, adv2;
    logic                 r_v1, r_v2;
    t_s1                  r_s1, n_s1;
    t_s2                  r_s2, n_s2;
    logic signed [DW-1:0] aws, ahs, bws, bhs;
    logic [CW-1:0]        cx, cy;

    assign ax = i_data[FLD_AX*CW +: CW];
    assign ay = i_data[FLD_AY*CW +: CW];
    assign aw = i_data[FLD_AW*CW +: CW];
    assign ah = i_data[FLD_AH*CW +: CW];
    assign bx = i_data[FLD_BX*CW +: CW];
    assign by = i_data[FLD_BY*CW +: CW];
    assign bw = i_data[FLD_BW*CW +: CW];
    assign bh = i_data[FLD_BH*CW +: CW];
    assign ex = i_data[FLD_EX*CW +: CW];
    assign ey = i_data[FLD_EY*CW +: CW];

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_s2    = r_s2;

    always_comb begin
        n_s1.action = t_action'(i_action);
        n_s1.dab_x  = DW'(ax) - DW'(bx);
        n_s1.dab_y  = DW'(ay) - DW'(by);
        n_s1.dse_x  = DW'(ex) - DW'(bx);
        n_s1.dse_y  = DW'(ey) - DW'(by);
        n_s1.dae_x  = DW'(ax) - DW'(ex);
        n_s1.dae_y  = DW'(ay) - DW'(ey);
        n_s1.aw     = aw;
        n_s1.ah     = ah;
        n_s1.bw     = bw;
        n_s1.bh     = bh;
        n_s1.rsum   = DW'(aw) + DW'(bw);
    end

    assign aws = $signed({1'b0, r_s1.aw});
    assign ahs = $signed({1'b0, r_s1.ah});
    assign bws = $signed({1'b0, r_s1.bw});
    assign bhs = $signed({1'b0, r_s1.bh});

    // clamp the circle centre into the box
    always_comb begin
        if (r_s1.dab_x < 0) begin
            cx = mag(r_s1.dab_x);
        end else if (r_s1.dab_x > bws) begin
            cx = CW'(r_s1.dab_x - bws);
        end else begin
            cx = '0;
        end
        if (r_s1.dab_y < 0) begin
            cy = mag(r_s1.dab_y);
        end else if (r_s1.dab_y > bhs) begin
            cy = CW'(r_s1.dab_y - bhs);
        end else begin
            cy = '0;
        end
    end

    always_comb begin
        n_s2.action = r_s1.action;
        case (r_s1.action)
            ACT_BOX_BOX: begin
                n_s2.hit_box = !(r_s1.dab_x >= bws || r_s1.dab_x <= -aws ||
                                 r_s1.dab_y >= bhs || r_s1.dab_y <= -ahs);
            end
            ACT_BOX_PT: begin
                n_s2.hit_box = (r_s1.dab_x <= 0) && (r_s1.dab_x >= -aws) &&
                               (r_s1.dab_y <= 0) && (r_s1.dab_y >= -ahs);
            end
            ACT_PT_PT: begin
                n_s2.hit_box = (r_s1.dab_x == 0) && (r_s1.dab_y == 0);
            end
            default: begin
                n_s2.hit_box = 1'b0;
            end
        endcase
        n_s2.m1x   = (r_s1.action == ACT_CIRC_BOX) ? cx : mag(r_s1.dab_x);
        n_s2.m1y   = (r_s1.action == ACT_CIRC_BOX) ? cy : mag(r_s1.dab_y);
        n_s2.mex   = mag(r_s1.dae_x);
        n_s2.mey   = mag(r_s1.dae_y);
        n_s2.mlx   = mag(r_s1.dse_x);
        n_s2.mly   = mag(r_s1.dse_y);
        n_s2.dab_x = r_s1.dab_x;
        n_s2.dab_y = r_s1.dab_y;
        n_s2.dse_x = r_s1.dse_x;
        n_s2.dse_y = r_s1.dse_y;
        n_s2.thr   = (r_s1.action == ACT_CIRC_CIRC) ? r_s1.rsum : DW'(r_s1.aw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (adv2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    a_pt_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_s2.hit_box && r_s2.action == ACT_PT_PT) |->
        (r_s2.m1x == '0 && r_s2.m1y == '0))
        else $error("point hit with nonzero distance");

    a_box_hit_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_s2.hit_box) |->
        (r_s2.action == ACT_BOX_BOX || r_s2.action == ACT_BOX_PT ||
         r_s2.action == ACT_PT_PT))
        else $error("box hit flagged in a circle mode");

endmodule

// ===== src/pct_prod.sv =====
`timescale 1ns / 1ps
// Product stages: squared distances, dot and cross products, then the
// per-mode threshold compares. Depends on pct_pkg.
module pct_prod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pct_pkg::t_s2  i_s2,
    output logic          o_ready,
    output logic          o_valid,
    output pct_pkg::t_s4  o_s4,
    input  logic          i_ready
);
    import pct_pkg::*;

    logic                 adv3, adv4;
    logic                 r_v3, r_v4;
    t_s3                  r_s3, n_s3;
    t_s4                  r_s4, n_s4;
    logic [TH2W-1:0]      d1, de;
    logic signed [PW-1:0] lens;

    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign o_ready = adv3;
    assign o_valid = r_v4;
    assign o_s4    = r_s4;

    always_comb begin
        n_s3.action  = i_s2.action;
        n_s3.hit_box = i_s2.hit_box;
        n_s3.dist1   = SQW'(sq(i_s2.m1x)) + SQW'(sq(i_s2.m1y));
        n_s3.diste   = SQW'(sq(i_s2.mex)) + SQW'(sq(i_s2.mey));
        n_s3.len2    = SQW'(sq(i_s2.mlx)) + SQW'(sq(i_s2.mly));
        n_s3.thr2    = TH2W'(i_s2.thr) * TH2W'(i_s2.thr);
        n_s3.dot     = PW'(smul(i_s2.dab_x, i_s2.dse_x)) + PW'(smul(i_s2.dab_y, i_s2.dse_y));
        n_s3.xprod   = PW'(smul(i_s2.dab_x, i_s2.dse_y)) - PW'(smul(i_s2.dab_y, i_s2.dse_x));
    end

    assign d1   = TH2W'(r_s3.dist1);
    assign de   = TH2W'(r_s3.diste);
    assign lens = $signed({{(PW-SQW){1'b0}}, r_s3.len2});

    always_comb begin
        n_s4.use_cross = 1'b0;
        n_s4.hit_pre   = 1'b0;
        case (r_s3.action)
            ACT_CIRC_CIRC: begin
                n_s4.hit_pre = d1 < r_s3.thr2;
            end
            ACT_CIRC_PT, ACT_CIRC_BOX: begin
                n_s4.hit_pre = d1 <= r_s3.thr2;
            end
            ACT_CIRC_SEG: begin
                if (r_s3.len2 == '0) begin
                    n_s4.hit_pre = d1 <= r_s3.thr2;
                end else if (r_s3.dot <= 0) begin
                    n_s4.hit_pre = d1 < r_s3.thr2;
                end else if (r_s3.dot >= lens) begin
                    n_s4.hit_pre = de < r_s3.thr2;
                end else begin
                    n_s4.use_cross = 1'b1;
                end
            end
            ACT_BOX_BOX, ACT_BOX_PT, ACT_PT_PT: begin
                n_s4.hit_pre = r_s3.hit_box;
            end
            default: begin
                n_s4.hit_pre = 1'b0;
            end
        endcase
        n_s4.cm   = r_s3.xprod[PW-1] ? CMW'(-r_s3.xprod) : CMW'(r_s3.xprod);
        n_s4.r2   = r_s3.thr2[R2W-1:0];
        n_s4.len2 = r_s3.len2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv3) begin
                r_v3 <= i_valid;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && i_valid) begin
            r_s3 <= n_s3;
        end
        if (adv4 && r_v3) begin
            r_s4 <= n_s4;
        end
    end

    a_cross_nonzero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_s4.use_cross) |-> (r_s4.len2 != '0 && !r_s4.hit_pre))
        else $error("cross compare selected for a degenerate segment");

endmodule

// ===== src/pct_wide.sv =====
`timescale 1ns / 1ps
// Wide product stages: cross squared and radius squared times length squared,
// built from split partial products and summed. Depends on pct_pkg.
module pct_wide (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pct_pkg::t_s4  i_s4,
    output logic          o_ready,
    output logic          o_valid,
    output pct_pkg::t_s6  o_s6,
    input  logic          i_ready
);
    import pct_pkg::*;

    logic           adv5, adv6;
    logic           r_v5, r_v6;
    t_s5            r_s5, n_s5;
    t_s6            r_s6, n_s6;
    logic [CHW-1:0] ch;
    logic [HW-1:0]  cl;
    logic [LHW-1:0] lh;
    logic [HW-1:0]  ll;

    assign adv6    = !r_v6 || i_ready;
    assign adv5    = !r_v5 || adv6;
    assign o_ready = adv5;
    assign o_valid = r_v6;
    assign o_s6    = r_s6;

    assign ch = i_s4.cm[CMW-1:HW];
    assign cl = i_s4.cm[HW-1:0];
    assign lh = i_s4.len2[SQW-1:HW];
    assign ll = i_s4.len2[HW-1:0];

    always_comb begin
        n_s5.use_cross = i_s4.use_cross;
        n_s5.hit_pre   = i_s4.hit_pre;
        n_s5.pp_hh     = (2*CHW)'(ch) * (2*CHW)'(ch);
        n_s5.pp_hl     = (CHW+HW)'(ch) * (CHW+HW)'(cl);
        n_s5.pp_ll     = (2*HW)'(cl) * (2*HW)'(cl);
        n_s5.rl_h      = (R2W+LHW)'(i_s4.r2) * (R2W+LHW)'(lh);
        n_s5.rl_l      = (R2W+HW)'(i_s4.r2) * (R2W+HW)'(ll);
    end

    always_comb begin
        n_s6.use_cross = r_s5.use_cross;
        n_s6.hit_pre   = r_s5.hit_pre;
        n_s6.c2        = (C2W'(r_s5.pp_hh) << (2 * HW)) + (C2W'(r_s5.pp_hl) << (HW + 1)) +
                         C2W'(r_s5.pp_ll);
        n_s6.rl        = (RLW'(r_s5.rl_h) << HW) + RLW'(r_s5.rl_l);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (adv5) begin
                r_v5 <= i_valid;
            end
            if (adv6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5 && i_valid) begin
            r_s5 <= n_s5;
        end
        if (adv6 && r_v5) begin
            r_s6 <= n_s6;
        end
    end

endmodule

// ===== src/primitive_collision_tester.sv =====
`timescale 1ns / 1ps
// Top level of the primitive collision tester: front, product and wide stages
// plus the output register. Depends on pct_pkg, pct_front, pct_prod, pct_wide.
//
// Usage:
//   Slave stream: one beat is one shape-pair test. tuser carries the test code
//   (circle-circle, circle-point, circle-box, box-box, box-point,
//   circle-segment, point-point; the unused code gives no hit). tdata carries
//   the coordinates and sizes of both shapes and the segment end.
//   Master stream: one beat per test, hit flag in tdata bit 0.
//   Pipeline: seven register stages (two front, two product, two wide-product,
//   one output). Throughput: one test per cycle while the receiver keeps
//   tready high, set by the fully pipelined datapath; every stage holds one
//   test.
//   Reset clears all stage valid bits; the block holds no other state and is
//   ready in the first cycle after reset.
//   Stall: when the receiver holds tready low the output beat holds, earlier
//   stages keep advancing into empty slots, and s_axis_tready falls only once
//   all seven stages are occupied. No beat is dropped or repeated.
module primitive_collision_tester (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, seg_end_x, seg_end_y
    input  logic [pct_pkg::SDW-1:0] s_axis_tdata,
    // action
    input  logic [pct_pkg::AW-1:0]  s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // hit, zero padding
    output logic [pct_pkg::MDW-1:0] m_axis_tdata
);
    import pct_pkg::*;

    logic  fr_valid, fr_ready;
    t_s2   fr_s2;
    logic  pr_valid, pr_ready;
    t_s4   pr_s4;
    logic  wd_valid, wd_ready;
    t_s6   wd_s6;
    logic  adv7;
    logic  r_out_v;
    logic  r_hit, n_hit;

    pct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .o_valid  (fr_valid),
        .o_s2     (fr_s2),
        .i_ready  (fr_ready)
    );

    pct_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_s2    (fr_s2),
        .o_ready (fr_ready),
        .o_valid (pr_valid),
        .o_s4    (pr_s4),
        .i_ready (pr_ready)
    );

    pct_wide u_wide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pr_valid),
        .i_s4    (pr_s4),
        .o_ready (pr_ready),
        .o_valid (wd_valid),
        .o_s6    (wd_s6),
        .i_ready (wd_ready)
    );

    assign adv7     = !r_out_v || m_axis_tready;
    assign wd_ready = adv7;

    // final compare of cross squared against radius squared times length squared
    assign n_hit = wd_s6.use_cross ? (wd_s6.c2 < C2W'(wd_s6.rl)) : wd_s6.hit_pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv7) begin
            r_out_v <= wd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv7 && wd_valid) begin
            r_hit <= n_hit;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(MDW-1){1'b0}}, r_hit};

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_no_beat_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output beat right after reset");

endmodule

// ===== tb/sv/primitive_collision_tester_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for primitive_collision_tester: directed shape-pair
// corner cases, then random pairs under sender and receiver stalls and at full rate.
// Depends on pct_pkg and the primitive_collision_tester RTL.
module primitive_collision_tester_test;
    import pct_pkg::*;

    localparam logic [AW-1:0] ACT_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [AW-1:0]        action;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic [CW-1:0]        aw;
        logic [CW-1:0]        ah;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [CW-1:0]        bw;
        logic [CW-1:0]        bh;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } t_shape_pair;

    logic           i_clk;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [SDW-1:0] s_axis_tdata = '0;   // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, seg_end_x, seg_end_y
    logic [AW-1:0]  s_axis_tuser = '0;   // action
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [MDW-1:0] m_axis_tdata;        // hit, zero padding

    bit pending_hits[$];
    bit expected_hit;
    int tx_idle_pct = 25;
    int rx_idle_pct = 53;
    int fail_cnt = 0;
    int sent_cnt = 0;
    int hit_cnt = 0;
    int stall_cnt = 0;

    primitive_collision_tester dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sq_dist(longint x0, longint y0, longint x1, longint y1);
        return (x0 - x1) * (x0 - x1) + (y0 - y1) * (y0 - y1);
    endfunction

    function automatic bit segment_hit(longint cx, longint cy, longint r,
                                       longint sx, longint sy, longint ex, longint ey);
        longint dx, dy, px, py, r2, len2, dot, xprod;
        logic [127:0] c2, rl;
        dx = ex - sx;
        dy = ey - sy;
        px = cx - sx;
        py = cy - sy;
        r2 = r * r;
        len2 = dx * dx + dy * dy;
        if (len2 == 0)
            return sq_dist(cx, cy, sx, sy) <= r2;
        dot = px * dx + py * dy;
        if (dot <= 0)
            return sq_dist(cx, cy, sx, sy) < r2;
        if (dot >= len2)
            return sq_dist(cx, cy, ex, ey) < r2;
        xprod = px * dy - py * dx;
        c2 = 128'(xprod < 0 ? -xprod : xprod);
        c2 = c2 * c2;
        rl = 128'(r2) * 128'(len2);
        return c2 < rl;
    endfunction

    function automatic bit collision_hit(t_shape_pair p);
        longint ax, ay, aw, ah, bx, by, bw, bh, ex, ey, rs, tx, ty;
        bit hit;
        ax = p.ax; ay = p.ay; aw = p.aw; ah = p.ah;
        bx = p.bx; by = p.by; bw = p.bw; bh = p.bh;
        ex = p.ex; ey = p.ey;
        hit = 1'b0;
        case (p.action)
            ACT_CIRC_CIRC: begin
                rs = aw + bw;
                hit = sq_dist(ax, ay, bx, by) < rs * rs;
            end
            ACT_CIRC_PT: hit = sq_dist(ax, ay, bx, by) <= aw * aw;
            ACT_CIRC_BOX: begin
                tx = ax;
                ty = ay;
                if (ax < bx) tx = bx;
                else if (ax > bx + bw) tx = bx + bw;
                if (ay < by) ty = by;
                else if (ay > by + bh) ty = by + bh;
                hit = sq_dist(ax, ay, tx, ty) <= aw * aw;
            end
            ACT_BOX_BOX: hit = !(ax >= bx + bw || ax + aw <= bx ||
                                 ay >= by + bh || ay + ah <= by);
            ACT_BOX_PT: hit = bx >= ax && bx <= ax + aw && by >= ay && by <= ay + ah;
            ACT_CIRC_SEG: hit = segment_hit(ax, ay, aw, bx, by, ex, ey);
            ACT_PT_PT: hit = ax == bx && ay == by;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic t_shape_pair pair_of(int act, int ax, int ay, int aw, int ah,
                                            int bx, int by, int bw, int bh,
                                            int ex, int ey);
        t_shape_pair p;
        p.action = AW'(act);
        p.ax = CW'(ax); p.ay = CW'(ay); p.aw = CW'(aw); p.ah = CW'(ah);
        p.bx = CW'(bx); p.by = CW'(by); p.bw = CW'(bw); p.bh = CW'(bh);
        p.ex = CW'(ex); p.ey = CW'(ey);
        return p;
    endfunction

    function automatic logic [CW-1:0] jitter(logic [CW-1:0] center, int span);
        return center + CW'($urandom_range(2 * span)) - CW'(span);
    endfunction

    function automatic t_shape_pair random_pair();
        t_shape_pair p;
        logic [CW-1:0] cx, cy;
        int span;
        p.action = ($urandom_range(31) == 0) ? ACT_UNUSED : AW'($urandom_range(6));
        if ($urandom_range(99) < 20) begin
            p.ax = CW'($urandom); p.ay = CW'($urandom);
            p.aw = CW'($urandom); p.ah = CW'($urandom);
            p.bx = CW'($urandom); p.by = CW'($urandom);
            p.bw = CW'($urandom); p.bh = CW'($urandom);
            p.ex = CW'($urandom); p.ey = CW'($urandom);
        end else begin
            cx = CW'($urandom);
            cy = CW'($urandom);
            span = ($urandom_range(3) == 0) ? 4000 : 64;
            p.ax = jitter(cx, span); p.ay = jitter(cy, span);
            p.bx = jitter(cx, span); p.by = jitter(cy, span);
            p.ex = jitter(cx, span); p.ey = jitter(cy, span);
            p.aw = CW'($urandom_range(span)); p.ah = CW'($urandom_range(span));
            p.bw = CW'($urandom_range(span)); p.bh = CW'($urandom_range(span));
            if (p.action == ACT_CIRC_SEG && $urandom_range(5) == 0) begin
                p.ex = p.bx;
                p.ey = p.by;
            end
        end
        return p;
    endfunction

    // enter and leave on a falling edge
    task automatic send_pair(input t_shape_pair p);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= p.action;
        s_axis_tdata <= {p.ey, p.ex, p.bh, p.bw, p.by, p.bx, p.ah, p.aw, p.ay, p.ax};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_hits = {pending_hits, collision_hit(p)};
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_corner_cases();
        send_pair(pair_of(ACT_CIRC_CIRC, 0, 0, 3, 0, 5, 0, 2, 0, 0, 0));
        send_pair(pair_of(ACT_CIRC_CIRC, 0, 0, 3, 0, 4, 0, 2, 0, 0, 0));
        send_pair(pair_of(ACT_CIRC_CIRC, -32768, -32768, 65535, 0,
                          32767, 32767, 65535, 0, 0, 0));
        send_pair(pair_of(ACT_CIRC_PT, 0, 0, 5, 0, 3, 4, 0, 0, 0, 0));
        send_pair(pair_of(ACT_CIRC_PT, 0, 0, 5, 0, 4, 4, 0, 0, 0, 0));
        send_pair(pair_of(ACT_CIRC_BOX, 5, 5, 1, 0, 0, 0, 10, 10, 0, 0));
        send_pair(pair_of(ACT_CIRC_BOX, -3, -4, 5, 0, 0, 0, 10, 10, 0, 0));
        send_pair(pair_of(ACT_CIRC_BOX, 14, 15, 5, 0, 0, 0, 10, 10, 0, 0));
        send_pair(pair_of(ACT_BOX_BOX, 0, 0, 10, 10, 10, 0, 5, 5, 0, 0));
        send_pair(pair_of(ACT_BOX_BOX, 0, 0, 10, 10, 9, 9, 5, 5, 0, 0));
        send_pair(pair_of(ACT_BOX_BOX, -32768, -32768, 65535, 65535,
                          32767, 32767, 65535, 65535, 0, 0));
        send_pair(pair_of(ACT_BOX_PT, 0, 0, 10, 10, 10, 10, 0, 0, 0, 0));
        send_pair(pair_of(ACT_BOX_PT, 0, 0, 10, 10, 11, 10, 0, 0, 0, 0));
        send_pair(pair_of(ACT_CIRC_SEG, 0, 0, 5, 0, 3, 4, 0, 0, 3, 4));
        send_pair(pair_of(ACT_CIRC_SEG, 0, 0, 5, 0, 3, 4, 0, 0, 10, 20));
        send_pair(pair_of(ACT_CIRC_SEG, 0, 0, 5, 0, 10, 20, 0, 0, 3, 4));
        send_pair(pair_of(ACT_CIRC_SEG, 0, 0, 6, 0, 10, 20, 0, 0, 3, 4));
        send_pair(pair_of(ACT_CIRC_SEG, 0, 0, 5, 0, -10, 5, 0, 0, 10, 5));
        send_pair(pair_of(ACT_CIRC_SEG, 0, 0, 6, 0, -10, 5, 0, 0, 10, 5));
        send_pair(pair_of(ACT_CIRC_SEG, 32767, -32768, 65535, 0,
                          -32768, -32768, 0, 0, 32767, 32767));
        send_pair(pair_of(ACT_PT_PT, -32768, 32767, 0, 0, -32768, 32767, 0, 0, 0, 0));
        send_pair(pair_of(ACT_PT_PT, -1, -1, 65535, 65535, -1, -2, 65535, 65535, -1, -1));
        send_pair(pair_of(ACT_UNUSED, 0, 0, 5, 5, 0, 0, 5, 5, 0, 0));
    endtask

    task automatic check_random_pairs(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    task automatic check_sender_pause();
        check_random_pairs(15);
        drain_results();
        check_random_pairs(15);
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected result beat: hit expected none, actual %0d",
                       m_axis_tdata[0]);
                fail_cnt++;
            end else begin
                expected_hit = pending_hits.pop_front();
                if (m_axis_tdata[0] !== expected_hit) begin
                    $error("hit mismatch: expected %0d, actual %0d",
                           expected_hit, m_axis_tdata[0]);
                    fail_cnt++;
                end
            end
            if (m_axis_tdata[0] === 1'b1)
                hit_cnt++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        check_corner_cases();
        check_random_pairs(160);
        tx_idle_pct = 53;
        rx_idle_pct = 25;
        check_random_pairs(160);
        check_sender_pause();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        check_random_pairs(160);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Checked %0d shape-pair beats across all seven tests and the unused code,",
                 sent_cnt);
        $display("with %0d hits, under sender and receiver stalls and a full-rate stretch.",
                 hit_cnt);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
